/* rtl/core/mpfb_pkg.sv */
`default_nettype none

package mpfb_pkg;

    localparam int SCREEN_WIDTH  = 128;
    localparam int SCREEN_HEIGHT = 64;
    localparam int STORE_BYTES   = 1024;

    localparam int ADDR_W = $clog2(STORE_BYTES);
    // wide enough for any pixel address before the range check
    localparam int FULL_W = 14;

    localparam logic [1:0] OUTLINE_LAST_PHASE = 2'd3;

    typedef enum logic [2:0] {
        KIND_SET_PIXEL   = 3'd0,
        KIND_CLEAR_PIXEL = 3'd1,
        KIND_VLINE       = 3'd2,
        KIND_HLINE       = 3'd3,
        KIND_RECT_LINE   = 3'd4,
        KIND_RECT_FILL   = 3'd5,
        KIND_CLEAR_ALL   = 3'd6,
        KIND_READ_BYTE   = 3'd7
    } kind_t;

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_DRAW,
        ST_READ,
        ST_READ_WAIT,
        ST_FINISH
    } state_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  x_start;
        logic [7:0]  y_start;
        logic [7:0]  x_end;
        logic [7:0]  y_end;
        logic [7:0]  run_length;
        logic [9:0]  byte_index;
    } in_item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       done_res;
    } out_item_t;

    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        mask;
        logic              on;
    } pix_t;

endpackage

`default_nettype wire

/* rtl/core/monochrome_page_framebuffer_draw.sv */
// 1-bit page-organized framebuffer with a drawing command engine.
// Input channel s_valid/s_ready/s_item carries one drawing command per item;
// output channel m_valid/m_ready/m_item returns one result per command, with
// read_data holding the store byte for a read and zero otherwise.
// The byte store is a single synchronous RAM. Drawing walks the affected
// pixels one per cycle, each a read-modify-write whose write follows the
// registered RAM read, with the written byte forwarded when the next pixel
// hits the same byte. An outline is walked as four blocks; clear all clears
// one byte per cycle.
// The next item is taken in the cycle after the result is loaded.
// After reset the RAM is cleared by a sweep of all STORE_BYTES bytes (1024),
// during which s_ready stays low.
// A stalled receiver holds the result in the output register; the engine
// then waits with the next result until the register frees up.
`default_nettype none

module monochrome_page_framebuffer_draw (
    input  wire                       aclk,
    input  wire                       aresetn,
    input  wire                       s_valid,
    output logic                      s_ready,
    input  wire mpfb_pkg::in_item_t   s_item,
    output logic                      m_valid,
    input  wire                       m_ready,
    output mpfb_pkg::out_item_t       m_item
);

    logic [7:0] frame_mem [mpfb_pkg::STORE_BYTES];

    mpfb_pkg::state_t   state_reg, state_next;
    mpfb_pkg::in_item_t cmd_reg, cmd_next;
    logic [mpfb_pkg::ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic               sweep_cmd_reg, sweep_cmd_next;
    logic [7:0]         res_data_reg, res_data_next;
    logic               m_valid_reg, m_valid_next;
    mpfb_pkg::out_item_t m_item_reg, m_item_next;

    logic                        s1_valid_reg;
    logic [mpfb_pkg::ADDR_W-1:0] s1_addr_reg;
    logic [7:0]                  s1_mask_reg;
    logic                        s1_on_reg;
    logic                        wr_valid_reg;
    logic [mpfb_pkg::ADDR_W-1:0] wr_addr_reg;
    logic [7:0]                  wr_data_reg;
    logic [7:0]                  rd_data_reg;

    mpfb_pkg::pix_t pix;
    logic           gen_last;
    logic           gen_start;
    logic           gen_en;
    logic           accept;
    logic           out_free;
    logic           clr_last;
    logic           rd_in_range;
    logic           load_out;
    logic           sweeping;
    logic [mpfb_pkg::ADDR_W-1:0] rd_addr;
    logic [7:0]     old_byte;
    logic [7:0]     new_byte;
    logic           mem_we;
    logic [mpfb_pkg::ADDR_W-1:0] mem_waddr;
    logic [7:0]     mem_wdata;

    mpfb_pixgen u_pixgen (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (gen_start),
        .enable  (gen_en),
        .cmd     (cmd_reg),
        .pix     (pix),
        .last    (gen_last)
    );

    assign accept      = s_valid && s_ready;
    assign out_free    = !m_valid_reg || m_ready;
    assign clr_last    = (clr_cnt_reg == mpfb_pkg::ADDR_W'(mpfb_pkg::STORE_BYTES - 1));
    assign rd_in_range = mpfb_pkg::FULL_W'(cmd_reg.byte_index)
                         < mpfb_pkg::FULL_W'(mpfb_pkg::STORE_BYTES);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            mpfb_pkg::ST_SWEEP: begin
                if (clr_last) begin
                    state_next = sweep_cmd_reg ? mpfb_pkg::ST_FINISH : mpfb_pkg::ST_IDLE;
                end
            end
            mpfb_pkg::ST_IDLE: begin
                if (s_valid) begin
                    case (s_item.kind)
                        mpfb_pkg::KIND_CLEAR_ALL: state_next = mpfb_pkg::ST_SWEEP;
                        mpfb_pkg::KIND_READ_BYTE: state_next = mpfb_pkg::ST_READ;
                        default:                  state_next = mpfb_pkg::ST_DRAW;
                    endcase
                end
            end
            mpfb_pkg::ST_DRAW: begin
                if (gen_last) begin
                    state_next = mpfb_pkg::ST_FINISH;
                end
            end
            mpfb_pkg::ST_READ:      state_next = mpfb_pkg::ST_READ_WAIT;
            mpfb_pkg::ST_READ_WAIT: state_next = mpfb_pkg::ST_FINISH;
            mpfb_pkg::ST_FINISH: begin
                if (out_free) begin
                    state_next = mpfb_pkg::ST_IDLE;
                end
            end
            default: state_next = mpfb_pkg::ST_IDLE;
        endcase
    end

    // outputs and datapath control
    always_comb begin
        s_ready   = (state_reg == mpfb_pkg::ST_IDLE);
        gen_en    = (state_reg == mpfb_pkg::ST_DRAW);
        sweeping  = (state_reg == mpfb_pkg::ST_SWEEP);
        load_out  = (state_reg == mpfb_pkg::ST_FINISH) && out_free;
        gen_start = accept;
        rd_addr   = (state_reg == mpfb_pkg::ST_READ)
                    ? mpfb_pkg::ADDR_W'(cmd_reg.byte_index) : pix.addr;

        cmd_next       = accept ? s_item : cmd_reg;
        clr_cnt_next   = sweeping ? clr_cnt_reg + 1'b1 : clr_cnt_reg;
        sweep_cmd_next = sweep_cmd_reg;
        res_data_next  = res_data_reg;
        if (accept) begin
            clr_cnt_next   = '0;
            sweep_cmd_next = 1'b1;
            res_data_next  = 8'h00;
        end
        if (state_reg == mpfb_pkg::ST_READ_WAIT) begin
            res_data_next = rd_in_range ? rd_data_reg : 8'h00;
        end

        m_valid_next = m_valid_reg && !m_ready;
        m_item_next  = m_item_reg;
        if (load_out) begin
            m_valid_next          = 1'b1;
            m_item_next.read_data = res_data_reg;
            m_item_next.done_res  = 1'b1;
        end
    end

    // read-modify-write with forwarding of the byte written last cycle
    assign old_byte = (wr_valid_reg && (wr_addr_reg == s1_addr_reg)) ? wr_data_reg : rd_data_reg;
    assign new_byte = s1_on_reg ? (old_byte | s1_mask_reg) : (old_byte & ~s1_mask_reg);

    always_comb begin
        mem_we    = s1_valid_reg || sweeping;
        mem_waddr = sweeping ? clr_cnt_reg : s1_addr_reg;
        mem_wdata = sweeping ? 8'h00 : new_byte;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            frame_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= frame_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        s1_addr_reg <= pix.addr;
        s1_mask_reg <= pix.mask;
        s1_on_reg   <= pix.on;
        wr_addr_reg <= s1_addr_reg;
        wr_data_reg <= new_byte;
        cmd_reg     <= cmd_next;
        res_data_reg <= res_data_next;
        m_item_reg  <= m_item_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= mpfb_pkg::ST_SWEEP;
            clr_cnt_reg   <= '0;
            sweep_cmd_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
            s1_valid_reg  <= 1'b0;
            wr_valid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            sweep_cmd_reg <= sweep_cmd_next;
            m_valid_reg   <= m_valid_next;
            s1_valid_reg  <= pix.valid;
            wr_valid_reg  <= s1_valid_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

`default_nettype wire

/* rtl/core/mpfb_pixgen.sv */
`default_nettype none

module mpfb_pixgen (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire                      start,
    input  wire                      enable,
    input  wire mpfb_pkg::in_item_t  cmd,
    output mpfb_pkg::pix_t           pix,
    output logic                     last
);

    logic [1:0] phase_reg, phase_next;
    logic [7:0] col_reg, col_next;
    logic [7:0] row_reg, row_next;

    logic [7:0] len;
    logic [7:0] ht;
    logic [7:0] bx;
    logic [7:0] by;
    logic [7:0] cols;
    logic [8:0] rows;
    logic       empty;
    logic       row_last;
    logic       col_last;
    logic       phase_done;
    logic       last_phase;
    logic [7:0] x;
    logic [7:0] y;
    logic [mpfb_pkg::FULL_W-1:0] addr_full;
    logic       on_screen;
    logic       in_store;

    assign len = cmd.x_end - cmd.x_start + 8'd1;
    assign ht  = cmd.y_end - cmd.y_start;

    // every drawing command is a sequence of up to four pixel blocks
    always_comb begin
        bx   = cmd.x_start;
        by   = cmd.y_start;
        cols = 8'd1;
        rows = 9'd1;
        case (cmd.kind)
            mpfb_pkg::KIND_VLINE: begin
                rows = {1'b0, cmd.run_length};
            end
            mpfb_pkg::KIND_HLINE: begin
                cols = cmd.run_length;
                rows = 9'd2;
            end
            mpfb_pkg::KIND_RECT_LINE: begin
                case (phase_reg)
                    2'd0: begin
                        cols = len;
                        rows = 9'd2;
                    end
                    2'd1: begin
                        by   = cmd.y_end;
                        cols = len;
                        rows = 9'd2;
                    end
                    2'd2: begin
                        rows = {1'b0, ht};
                    end
                    default: begin
                        bx   = cmd.x_end;
                        rows = {1'b0, ht};
                    end
                endcase
            end
            mpfb_pkg::KIND_RECT_FILL: begin
                cols = len;
                rows = {1'b0, ht} + 9'd1;
            end
            default: begin
                cols = 8'd1;
            end
        endcase
    end

    assign empty      = (cols == 8'd0) || (rows == 9'd0);
    assign row_last   = ({1'b0, row_reg} == rows - 9'd1);
    assign col_last   = (col_reg == cols - 8'd1);
    assign phase_done = empty || (row_last && col_last);
    assign last_phase = (cmd.kind != mpfb_pkg::KIND_RECT_LINE)
                        || (phase_reg == mpfb_pkg::OUTLINE_LAST_PHASE);
    assign last       = enable && phase_done && last_phase;

    assign x = bx + col_reg;
    assign y = by + row_reg;

    assign addr_full = mpfb_pkg::FULL_W'(x)
                     + mpfb_pkg::FULL_W'(y[7:3]) * mpfb_pkg::FULL_W'(mpfb_pkg::SCREEN_WIDTH);
    assign on_screen = ({1'b0, x} < 9'(mpfb_pkg::SCREEN_WIDTH))
                    && ({1'b0, y} < 9'(mpfb_pkg::SCREEN_HEIGHT));
    assign in_store  = addr_full < mpfb_pkg::FULL_W'(mpfb_pkg::STORE_BYTES);

    always_comb begin
        pix.valid = enable && !empty && on_screen && in_store;
        pix.addr  = addr_full[mpfb_pkg::ADDR_W-1:0];
        pix.mask  = 8'd1 << y[2:0];
        pix.on    = (cmd.kind != mpfb_pkg::KIND_CLEAR_PIXEL);
    end

    always_comb begin
        phase_next = phase_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        if (start) begin
            phase_next = 2'd0;
            col_next   = 8'd0;
            row_next   = 8'd0;
        end else if (enable) begin
            if (phase_done) begin
                col_next = 8'd0;
                row_next = 8'd0;
                if (!last_phase) begin
                    phase_next = phase_reg + 2'd1;
                end
            end else if (row_last) begin
                row_next = 8'd0;
                col_next = col_reg + 8'd1;
            end else begin
                row_next = row_reg + 8'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= 2'd0;
            col_reg   <= 8'd0;
            row_reg   <= 8'd0;
        end else begin
            phase_reg <= phase_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/mpfb_checker.sv */
`default_nettype none

module mpfb_checker (
    input wire                       aclk,
    input wire                       aresetn,
    input wire                       s_valid,
    input wire                       s_ready,
    input wire mpfb_pkg::in_item_t   s_item,
    input wire                       m_valid,
    input wire                       m_ready,
    input wire mpfb_pkg::out_item_t  m_item
);

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result changed while stalled");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_item.done_res)
        else $error("result without done flag");

    // the clearing pass keeps the input closed after reset
    assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("input open right after reset");

    // clear all sweeps the store before the next item
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_item.kind == mpfb_pkg::KIND_CLEAR_ALL)
        |=> !s_ready ##1 !s_ready)
        else $error("input open during clear sweep");

    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("two items accepted back to back");

endmodule

bind monochrome_page_framebuffer_draw mpfb_checker u_mpfb_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_item  (s_item),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);

`default_nettype wire
